FILE: hw/rtl/ccwb_pkg.sv
// Package for the coalescing configuration write buffer.
// Holds payload structs, codes, reset values and the address-to-store mapping.
// No dependencies.
`timescale 1ns / 1ps

package ccwb_pkg;

  localparam int QueueDepthDefault = 4;
  localparam int CmdQueueDepth     = 2;
  localparam int CfgIdxW           = 3;
  localparam int NumStored         = 3;

  localparam logic [7:0] RevisionByte = 8'h01;
  localparam logic [7:0] ReadMiss     = 8'hFF;

  localparam logic [7:0] DeviceIdRst   = 8'd0;
  localparam logic [7:0] IdAddrRst     = 8'd0;
  localparam logic [7:0] HwRevAddrRst  = 8'd1;
  localparam logic [7:0] SwRevAddrRst  = 8'd2;
  localparam logic [7:0] WaterAddrRst  = 8'd16;
  localparam logic [7:0] FuelAddrRst   = 8'd17;
  localparam logic [7:0] BattAddrRst   = 8'd18;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DRAIN = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SLOT_WATER   = 2'd0,
    SLOT_FUEL    = 2'd1,
    SLOT_BATTERY = 2'd2,
    SLOT_NONE    = 2'd3
  } slot_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_ID   = 3'd0,
    CFG_ID_ADDR     = 3'd1,
    CFG_HW_REV_ADDR = 3'd2,
    CFG_SW_REV_ADDR = 3'd3,
    CFG_WATER_ADDR  = 3'd4,
    CFG_FUEL_ADDR   = 3'd5,
    CFG_BATT_ADDR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_dropped;
    logic       drain_done;
    logic       programmed;
    logic       flush_pending;
    logic [1:0] queue_count;
  } result_t;

  typedef struct packed {
    logic [7:0] device_id;
    logic [7:0] id_address;
    logic [7:0] hw_rev_address;
    logic [7:0] sw_rev_address;
    logic [7:0] water_address;
    logic [7:0] fuel_address;
    logic [7:0] battery_address;
  } cfg_t;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] value;
    logic       ident_hit;
    logic [7:0] ident_data;
    slot_e      slot;
  } cmd_t;

  // Map a protocol address onto a store byte; water wins, then fuel, then battery.
  function automatic slot_e store_slot(input logic [7:0] addr, input cfg_t cfg);
    slot_e s;
    if (addr == cfg.water_address) begin
      s = SLOT_WATER;
    end else if (addr == cfg.fuel_address) begin
      s = SLOT_FUEL;
    end else if (addr == cfg.battery_address) begin
      s = SLOT_BATTERY;
    end else begin
      s = SLOT_NONE;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/ccwb_front.sv
// Front end of the coalescing configuration write buffer.
// Decodes identity addresses and the store mapping of each incoming transaction.
// Depends on ccwb_pkg.
`timescale 1ns / 1ps

module ccwb_front (
  input  ccwb_pkg::item_t item_i,
  input  ccwb_pkg::cfg_t  cfg_i,
  output ccwb_pkg::cmd_t  cmd_o
);

  always_comb begin
    cmd_o.kind       = item_i.kind;
    cmd_o.address    = item_i.address;
    cmd_o.value      = item_i.value;
    cmd_o.slot       = ccwb_pkg::store_slot(item_i.address, cfg_i);
    cmd_o.ident_hit  = 1'b1;
    cmd_o.ident_data = ccwb_pkg::RevisionByte;
    // Identity addresses win in the order id, hardware, software.
    priority if (item_i.address == cfg_i.id_address) begin
      cmd_o.ident_data = cfg_i.device_id;
    end else if (item_i.address == cfg_i.hw_rev_address) begin
      cmd_o.ident_data = ccwb_pkg::RevisionByte;
    end else if (item_i.address == cfg_i.sw_rev_address) begin
      cmd_o.ident_data = ccwb_pkg::RevisionByte;
    end else begin
      cmd_o.ident_hit = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/ccwb_queue.sv
// Short command queue between front end and back end.
// Small FIFO of classified transactions; depth from ccwb_pkg.
// Depends on ccwb_pkg.
`timescale 1ns / 1ps

module ccwb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccwb_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ccwb_pkg::cmd_t pop_data_o
);

  localparam int Depth = ccwb_pkg::CmdQueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ccwb_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/ccwb_back.sv
// Back end of the coalescing configuration write buffer.
// Holds the coalescing ring and the three-byte store, executes one transaction
// per cycle while the output is not stalled and registers the result. Depends on ccwb_pkg.
`timescale 1ns / 1ps

module ccwb_back #(
  parameter int QueueDepth = ccwb_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccwb_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  input  ccwb_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ccwb_pkg::result_t out_result_o
);

  localparam int IdxW = $clog2(QueueDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
  localparam logic [IdxW:0]   DepthW  = (IdxW + 1)'(QueueDepth);

  logic [7:0] entry_addr_q [QueueDepth];
  logic [7:0] entry_val_q  [QueueDepth];
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [7:0] stored_q [ccwb_pkg::NumStored];
  logic [7:0] stored_d [ccwb_pkg::NumStored];

  logic              out_valid_q;
  ccwb_pkg::result_t result_q, result_d;

  logic                  fire;
  logic [IdxW-1:0]       count, count_after;
  logic [IdxW+1:0]       count_wide;
  logic [QueueDepth-1:0] in_ring, match, merge_we;
  logic                  found, append_we;
  logic [7:0]            match_value, slot_byte, head_byte;
  ccwb_pkg::slot_e       head_slot;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] ring_count(input logic [IdxW-1:0] h,
                                                 input logic [IdxW-1:0] t);
    logic [IdxW:0] wrapped;
    wrapped = {1'b0, t} + DepthW - {1'b0, h};
    return (t >= h) ? t - h : wrapped[IdxW-1:0];
  endfunction

  function automatic logic [7:0] byte_of(input ccwb_pkg::slot_e s,
                                         input logic [7:0] b0,
                                         input logic [7:0] b1,
                                         input logic [7:0] b2);
    logic [7:0] r;
    unique case (s)
      ccwb_pkg::SLOT_WATER:   r = b0;
      ccwb_pkg::SLOT_FUEL:    r = b1;
      ccwb_pkg::SLOT_BATTERY: r = b2;
      default:                r = ccwb_pkg::ReadMiss;
    endcase
    return r;
  endfunction

  assign fire         = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o    = fire;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;
  assign count        = ring_count(head_q, tail_q);

  // Occupancy and address match over the live part of the ring.
  always_comb begin
    logic [IdxW:0] pos, off;
    match_value = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      pos        = (IdxW + 1)'(i);
      off        = (pos >= {1'b0, head_q}) ? pos - {1'b0, head_q}
                                           : pos + DepthW - {1'b0, head_q};
      in_ring[i] = (off < {1'b0, count});
      match[i]   = in_ring[i] && (entry_addr_q[i] == cmd_i.address);
      if (match[i]) begin
        match_value = match_value | entry_val_q[i];
      end
    end
    found = |match;
  end

  assign slot_byte = byte_of(cmd_i.slot, stored_q[0], stored_q[1], stored_q[2]);
  assign head_slot = ccwb_pkg::store_slot(entry_addr_q[head_q], cfg_i);
  assign head_byte = byte_of(head_slot, stored_q[0], stored_q[1], stored_q[2]);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    stored_d  = stored_q;
    merge_we  = '0;
    append_we = 1'b0;
    result_d  = '0;
    unique case (ccwb_pkg::kind_e'(cmd_i.kind))
      ccwb_pkg::KIND_READ: begin
        if (cmd_i.ident_hit) begin
          result_d.read_data = cmd_i.ident_data;
        end else if (found) begin
          result_d.read_data = match_value;
        end else begin
          result_d.read_data = slot_byte;
        end
      end
      ccwb_pkg::KIND_WRITE: begin
        if (cmd_i.slot != ccwb_pkg::SLOT_NONE) begin
          if (found) begin
            merge_we = match;
          end else if (ring_next(tail_q) != head_q) begin
            append_we = 1'b1;
            tail_d    = ring_next(tail_q);
          end else begin
            result_d.write_dropped = 1'b1;
          end
        end
      end
      ccwb_pkg::KIND_DRAIN: begin
        if (count != '0) begin
          if (head_slot != ccwb_pkg::SLOT_NONE && head_byte != entry_val_q[head_q]) begin
            stored_d[head_slot] = entry_val_q[head_q];
            result_d.programmed = 1'b1;
          end
          head_d              = ring_next(head_q);
          result_d.drain_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    count_after            = ring_count(head_d, tail_d);
    count_wide             = (IdxW + 2)'(count_after);
    result_d.flush_pending = (count_after != '0);
    result_d.queue_count   = count_wide[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < ccwb_pkg::NumStored; s++) begin
        stored_q[s] <= '0;
      end
    end else begin
      if (fire) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        stored_q    <= stored_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
      for (int i = 0; i < QueueDepth; i++) begin
        if (merge_we[i]) begin
          entry_val_q[i] <= cmd_i.value;
        end
      end
      if (append_we) begin
        entry_addr_q[tail_q] <= cmd_i.address;
        entry_val_q[tail_q]  <= cmd_i.value;
      end
    end
  end

endmodule

FILE: hw/rtl/coalescing_config_write_buffer.sv
// Coalescing configuration write buffer: ring queue of pending byte writes in
// front of a three-byte store. Top level; instantiates ccwb_front, ccwb_queue
// and ccwb_back. Depends on ccwb_pkg.
//
// Each transaction is a read, a write, a drain or the unused kind code, which
// does nothing, and yields exactly one result. The block sustains one
// transaction per clock cycle while the output is not stalled: the back end
// compares the address against every live ring slot in parallel and updates the
// ring, the store and the result register together, so the ring update in the
// back end sets the rate. An accepted transaction is written into the command
// queue; the back end pops it from there and registers its result in the output
// register. The front end classifies each transaction against the configured
// addresses and pushes it into a two-entry command queue; in_stall_o rises only
// while that queue is full and has no combinational path from out_stall_i. The
// ring holds at most QueueDepth-1 entries; a write to a store-mapped address
// already queued merges into that entry, and a write that finds the ring full
// is dropped and flagged. Write configuration only while the block is idle. No
// clearing pass runs after reset.
`timescale 1ns / 1ps

module coalescing_config_write_buffer #(
  parameter int QueueDepth = ccwb_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ccwb_pkg::item_t                in_item_i,
  // Results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ccwb_pkg::result_t              out_result_o,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [ccwb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  ccwb_pkg::cfg_t cfg_q;
  ccwb_pkg::cmd_t front_cmd, queue_cmd;
  logic           queue_full, queue_valid, queue_pop, push;

  // Hold the configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id       <= ccwb_pkg::DeviceIdRst;
      cfg_q.id_address      <= ccwb_pkg::IdAddrRst;
      cfg_q.hw_rev_address  <= ccwb_pkg::HwRevAddrRst;
      cfg_q.sw_rev_address  <= ccwb_pkg::SwRevAddrRst;
      cfg_q.water_address   <= ccwb_pkg::WaterAddrRst;
      cfg_q.fuel_address    <= ccwb_pkg::FuelAddrRst;
      cfg_q.battery_address <= ccwb_pkg::BattAddrRst;
    end else if (cfg_we_i) begin
      unique case (ccwb_pkg::cfg_idx_e'(cfg_index_i))
        ccwb_pkg::CFG_DEVICE_ID:   cfg_q.device_id       <= cfg_data_i;
        ccwb_pkg::CFG_ID_ADDR:     cfg_q.id_address      <= cfg_data_i;
        ccwb_pkg::CFG_HW_REV_ADDR: cfg_q.hw_rev_address  <= cfg_data_i;
        ccwb_pkg::CFG_SW_REV_ADDR: cfg_q.sw_rev_address  <= cfg_data_i;
        ccwb_pkg::CFG_WATER_ADDR:  cfg_q.water_address   <= cfg_data_i;
        ccwb_pkg::CFG_FUEL_ADDR:   cfg_q.fuel_address    <= cfg_data_i;
        ccwb_pkg::CFG_BATT_ADDR:   cfg_q.battery_address <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Accept whenever the command queue has room.
  assign in_stall_o = queue_full;
  assign push       = in_valid_i && !queue_full;

  ccwb_front u_front (
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .cmd_o  (front_cmd)
  );

  ccwb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_cmd)
  );

  ccwb_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule

FILE: hw/rtl/ccwb_checker.sv
// Port-level checks for the coalescing configuration write buffer.
// Bound to the top level below. Depends on ccwb_pkg.
`timescale 1ns / 1ps

module ccwb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              stall_i,
  input ccwb_pkg::result_t result_i
);

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_i |=> valid_i && $stable(result_i))
    else $error("stalled result changed");

  // Programming the store only happens on a drain that retired an entry.
  a_prog_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && result_i.programmed |-> result_i.drain_done && result_i.read_data == 8'h00)
    else $error("programmed without drain");

  // A dropped write leaves a full, non-empty ring and is not a drain.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && result_i.write_dropped |->
      result_i.flush_pending && !result_i.drain_done && result_i.read_data == 8'h00)
    else $error("dropped write with empty ring");

  // An empty ring reports a zero count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !result_i.flush_pending |-> result_i.queue_count == 2'd0)
    else $error("count nonzero on empty ring");

endmodule

bind coalescing_config_write_buffer ccwb_checker u_ccwb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (out_valid_o),
  .stall_i  (out_stall_i),
  .result_i (out_result_o)
);

FILE: tb/coalescing_config_write_buffer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for coalescing_config_write_buffer: directed steps, then random phases.
// Predicts every result with its own copy of the write ring and the three-byte store.
// Depends on ccwb_pkg and the RTL of the block; reads no file.

module coalescing_config_write_buffer_tb;
  import ccwb_pkg::*;

  localparam int         RingDepth     = QueueDepthDefault;
  localparam logic [1:0] KindUnused    = 2'd3;   // no operation behind this code
  localparam int         NumPhases     = 8;
  localparam int         ItemsPerPhase = 100;
  localparam int         WatchdogLimit = 1000;   // cycles with no transaction on either side
  localparam int         HoldOffCycles = 80;
  localparam int         HoldOffAfter  = 270;    // results taken before the long hold-off
  localparam int         MaxPrinted    = 100;
  localparam int         TailCycles    = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  item_t              in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  result_t            out_result_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0]         cfg_data_i;

  coalescing_config_write_buffer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // One row of the directed part: either a register write or a transaction, the latter
  // optionally with a result typed in by hand.
  typedef struct {
    logic     is_cfg;
    cfg_idx_e reg_idx;
    logic [7:0] reg_data;
    item_t    item;
    logic     has_lit;
    result_t  lit;
  } step_t;

  // Shadow of the block: registers, ring slots, ring pointers and the store.
  cfg_t        mirror_cfg;
  logic [7:0]  mirror_addr [RingDepth];
  logic [7:0]  mirror_val  [RingDepth];
  int unsigned mirror_head;
  int unsigned mirror_tail;
  logic [7:0]  mirror_nvm  [NumStored];

  result_t     expected_outcomes[$];
  step_t       directed_steps[$];
  int unsigned mismatches;
  int unsigned results_taken;
  int unsigned quiet_cycles;
  int unsigned send_calm;
  int unsigned recv_calm;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  function automatic int unsigned ring_step(input int unsigned i);
    return (i + 1 >= RingDepth) ? 0 : i + 1;
  endfunction

  // Store byte behind an address, -1 when unmapped; water beats fuel beats battery.
  function automatic int nvm_index(input logic [7:0] addr);
    if (addr == mirror_cfg.water_address) return 0;
    if (addr == mirror_cfg.fuel_address) return 1;
    if (addr == mirror_cfg.battery_address) return 2;
    return -1;
  endfunction

  // Apply one transaction to the shadow and return the result it must produce.
  function automatic result_t buffer_outcome(input item_t it);
    result_t     r;
    int unsigned i;
    int unsigned cnt;
    int          slot;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    case (it.kind)
      KIND_READ: begin
        // Identity addresses shadow everything, then a pending write, then the store.
        if (it.address == mirror_cfg.id_address) begin
          r.read_data = mirror_cfg.device_id;
        end else if (it.address == mirror_cfg.hw_rev_address ||
                     it.address == mirror_cfg.sw_rev_address) begin
          r.read_data = RevisionByte;
        end else begin
          for (i = mirror_head; i != mirror_tail; i = ring_step(i)) begin
            if (mirror_addr[i] == it.address) begin
              r.read_data = mirror_val[i];
              hit = 1'b1;
            end
          end
          if (!hit) begin
            slot = nvm_index(it.address);
            r.read_data = (slot < 0) ? ReadMiss : mirror_nvm[slot];
          end
        end
      end
      KIND_WRITE: begin
        // Only store-mapped addresses enter the ring; merge into a queued entry first.
        if (nvm_index(it.address) >= 0) begin
          for (i = mirror_head; i != mirror_tail && !hit; i = ring_step(i)) begin
            if (mirror_addr[i] == it.address) begin
              mirror_val[i] = it.value;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (ring_step(mirror_tail) != mirror_head) begin
              mirror_addr[mirror_tail] = it.address;
              mirror_val[mirror_tail]  = it.value;
              mirror_tail = ring_step(mirror_tail);
            end else begin
              r.write_dropped = 1'b1;
            end
          end
        end
      end
      KIND_DRAIN: begin
        // Retire the head; an entry whose address lost its mapping writes nothing.
        if (mirror_head != mirror_tail) begin
          slot = nvm_index(mirror_addr[mirror_head]);
          if (slot >= 0 && mirror_nvm[slot] != mirror_val[mirror_head]) begin
            mirror_nvm[slot] = mirror_val[mirror_head];
            r.programmed = 1'b1;
          end
          mirror_head = ring_step(mirror_head);
          r.drain_done = 1'b1;
        end
      end
      default: ;
    endcase
    cnt = (mirror_tail + RingDepth - mirror_head) % RingDepth;
    r.flush_pending = (cnt != 0);
    r.queue_count   = cnt[1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Directed rows
  // ------------------------------------------------------------------------

  function automatic result_t result_of(input logic [7:0] rd, input logic drop, done, prog,
                                        input logic [1:0] cnt);
    result_t r;
    r.read_data     = rd;
    r.write_dropped = drop;
    r.drain_done    = done;
    r.programmed    = prog;
    r.flush_pending = (cnt != 0);
    r.queue_count   = cnt;
    return r;
  endfunction

  function automatic step_t txn(input logic [1:0] kind, input logic [7:0] addr, value,
                                input logic has_lit, input result_t lit);
    step_t s;
    s.is_cfg   = 1'b0;
    s.reg_idx  = CFG_DEVICE_ID;
    s.reg_data = '0;
    s.item     = {kind, addr, value};
    s.has_lit  = has_lit;
    s.lit      = lit;
    return s;
  endfunction

  function automatic step_t cfg_row(input cfg_idx_e idx, input logic [7:0] data);
    step_t s;
    s.is_cfg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    s.item     = '0;
    s.has_lit  = 1'b0;
    s.lit      = '0;
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------

  // Draw a random wait; now and then start a calm stretch with no waits at all.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Offer one transaction from a falling edge; hold it until accepted, then predict.
  task automatic send_txn(input item_t it, input logic has_lit, input result_t lit);
    int unsigned gap;
    result_t     predicted;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = buffer_outcome(it);
    expected_outcomes.push_back(has_lit ? lit : predicted);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every transaction in flight has produced its result.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // One register write, mirrored into the shadow; call only while the block is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_DEVICE_ID:   mirror_cfg.device_id       = data;
      CFG_ID_ADDR:     mirror_cfg.id_address      = data;
      CFG_HW_REV_ADDR: mirror_cfg.hw_rev_address  = data;
      CFG_SW_REV_ADDR: mirror_cfg.sw_rev_address  = data;
      CFG_WATER_ADDR:  mirror_cfg.water_address   = data;
      CFG_FUEL_ADDR:   mirror_cfg.fuel_address    = data;
      CFG_BATT_ADDR:   mirror_cfg.battery_address = data;
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input logic [7:0] got, want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s got %0h want %0h", results_taken, field, got,
                              want));
    end
  endtask

  // Pop the oldest expectation for every result transaction and compare field by field.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        note_mismatch($sformatf("result %0h with no transaction waiting", out_result_o));
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("read_data", out_result_o.read_data, want.read_data);
        compare_field("write_dropped", out_result_o.write_dropped, want.write_dropped);
        compare_field("drain_done", out_result_o.drain_done, want.drain_done);
        compare_field("programmed", out_result_o.programmed, want.programmed);
        compare_field("flush_pending", out_result_o.flush_pending, want.flush_pending);
        compare_field("queue_count", out_result_o.queue_count, want.queue_count);
      end
      results_taken++;
    end
  end

  // Watchdog: end the run when neither side has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[coalescing_config_write_buffer] ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Clock, receiver and stimulus
  // ------------------------------------------------------------------------

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stall a random number of cycles before each result, and once hold off
  // for a long stretch so the block fills up and stalls its input side.
  initial begin : receiver
    int unsigned hold;
    logic        held_off;
    held_off    = 1'b0;
    recv_calm   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_taken >= HoldOffAfter) begin
        hold     = HoldOffCycles;
        held_off = 1'b1;
      end else begin
        hold = draw_gap(recv_calm);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    item_t       it;
    cfg_t        setting;
    logic [7:0]  pool [6];
    int unsigned p;
    int unsigned n;
    int unsigned pick;

    // Drive every input to a known value before reset.
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    results_taken = 0;
    quiet_cycles  = 0;
    send_calm     = 0;

    // Shadow starts at the reset values of the block.
    mirror_cfg = {DeviceIdRst, IdAddrRst, HwRevAddrRst, SwRevAddrRst,
                  WaterAddrRst, FuelAddrRst, BattAddrRst};
    for (n = 0; n < RingDepth; n++) begin
      mirror_addr[n] = '0;
      mirror_val[n]  = '0;
    end
    for (n = 0; n < NumStored; n++) mirror_nvm[n] = '0;
    mirror_head = 0;
    mirror_tail = 0;

    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the reset register values.
    // Identity reads, a store read, a miss, an empty drain and the unused kind.
    directed_steps.push_back(txn(KIND_READ, 8'd0, 8'h00, 1'b1, result_of(8'h00, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_READ, 8'd1, 8'h00, 1'b1, result_of(8'h01, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_READ, 8'd2, 8'hFF, 1'b1, result_of(8'h01, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_READ, 8'd16, 8'h00, 1'b1, result_of(8'h00, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_READ, 8'd255, 8'h00, 1'b1, result_of(8'hFF, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b1, result_of(8'h00, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KindUnused, 8'hFF, 8'hFF, 1'b1, result_of(8'h00, 0, 0, 0, 0)));
    // Unmapped write is ignored; fill the ring, merging repeated addresses.
    directed_steps.push_back(txn(KIND_WRITE, 8'd3, 8'hAA, 1'b1, result_of(8'h00, 0, 0, 0, 0)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd16, 8'hFF, 1'b1, result_of(8'h00, 0, 0, 0, 1)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd16, 8'h00, 1'b1, result_of(8'h00, 0, 0, 0, 1)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd17, 8'h80, 1'b1, result_of(8'h00, 0, 0, 0, 2)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd18, 8'h7F, 1'b1, result_of(8'h00, 0, 0, 0, 3)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd16, 8'h55, 1'b1, result_of(8'h00, 0, 0, 0, 3)));
    // A queued value shadows the store on read; draining it programs the byte.
    directed_steps.push_back(txn(KIND_READ, 8'd16, 8'h00, 1'b1, result_of(8'h55, 0, 0, 0, 3)));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b1, result_of(8'h00, 0, 1, 1, 2)));
    directed_steps.push_back(txn(KIND_WRITE, 8'd16, 8'h00, 1'b0, '0));
    // Remap water while the ring is full: a write to the new address is dropped,
    // and the entry queued under the old address retires without programming.
    directed_steps.push_back(cfg_row(CFG_WATER_ADDR, 8'hFF));
    directed_steps.push_back(txn(KIND_WRITE, 8'hFF, 8'h11, 1'b1, result_of(8'h00, 1, 0, 0, 3)));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b0, '0));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b0, '0));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b1, result_of(8'h00, 0, 1, 0, 0)));
    directed_steps.push_back(txn(KIND_READ, 8'd16, 8'h00, 1'b1, result_of(8'hFF, 0, 0, 0, 0)));
    // Device id collides with the water address: identity wins the read, the write still
    // lands in the ring.
    directed_steps.push_back(cfg_row(CFG_DEVICE_ID, 8'hFF));
    directed_steps.push_back(cfg_row(CFG_ID_ADDR, 8'hFF));
    directed_steps.push_back(txn(KIND_WRITE, 8'hFF, 8'h22, 1'b0, '0));
    directed_steps.push_back(txn(KIND_READ, 8'hFF, 8'h00, 1'b1, result_of(8'hFF, 0, 0, 0, 1)));
    directed_steps.push_back(txn(KIND_DRAIN, 8'd0, 8'h00, 1'b0, '0));

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg) begin
        settle();
        write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_data);
      end else begin
        send_txn(directed_steps[k].item, directed_steps[k].has_lit, directed_steps[k].lit);
      end
    end

    // Random phases. Each starts with a full register load while the block is idle;
    // entries still queued from the previous phase get remapped on purpose.
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0:       setting = {8'hFF, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFE};
        1:       setting = '0;   // every address collides
        2:       setting = {8'h5A, 8'h20, 8'h21, 8'h22, 8'h10, 8'h11, 8'h12};
        default: begin
          // Mix narrow address ranges (collisions likely) with the full range.
          setting.device_id       = $urandom_range(0, 255);
          setting.id_address      = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
          setting.hw_rev_address  = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
          setting.sw_rev_address  = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
          setting.water_address   = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
          setting.fuel_address    = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
          setting.battery_address = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255);
        end
      endcase
      settle();
      write_reg(CFG_DEVICE_ID, setting.device_id);
      write_reg(CFG_ID_ADDR, setting.id_address);
      write_reg(CFG_HW_REV_ADDR, setting.hw_rev_address);
      write_reg(CFG_SW_REV_ADDR, setting.sw_rev_address);
      write_reg(CFG_WATER_ADDR, setting.water_address);
      write_reg(CFG_FUEL_ADDR, setting.fuel_address);
      write_reg(CFG_BATT_ADDR, setting.battery_address);

      // Aim most transactions at configured addresses so they hit the ring and store.
      pool[0] = setting.id_address;
      pool[1] = setting.hw_rev_address;
      pool[2] = setting.sw_rev_address;
      pool[3] = setting.water_address;
      pool[4] = setting.fuel_address;
      pool[5] = setting.battery_address;

      for (n = 0; n < ItemsPerPhase; n++) begin
        // Slightly more writes than drains, so the ring fills and drops occur.
        pick       = $urandom_range(0, 99);
        it.kind    = (pick < 35) ? KIND_READ  :
                     (pick < 72) ? KIND_WRITE :
                     (pick < 94) ? KIND_DRAIN : KindUnused;
        it.address = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)]
                                                : $urandom_range(0, 255);
        it.value   = $urandom_range(0, 255);
        send_txn(it, 1'b0, '0);
      end
    end

    // Wait out every outstanding result, then wait out the tail to catch any strays.
    settle();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[coalescing_config_write_buffer] OK");
    end else begin
      $display("[coalescing_config_write_buffer] ERROR");
    end
    $finish;
  end

endmodule
